### sv/rchl_pkg.sv
// Shared definitions for the rating curve height lookup block.
// Holds the command and status structs, result codes and default sizes.
// No dependencies; imported by every module of the block.
`default_nettype none

package rchl_pkg;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam int REACH_COUNT_DEF = 4;

  localparam int DISCH_W   = 32;
  localparam int STEP_W    = 16;
  localparam int LEN_W     = 9;
  localparam int HEIGHT_W  = 24;
  localparam int STATUS_W  = 2;
  localparam int PROD_W    = DISCH_W + STEP_W;
  localparam int QUO_W     = STEP_W;
  localparam int DIV_CNT_W = $clog2(QUO_W);

  localparam logic [LEN_W-1:0]  LEN_RESET  = 9'd0;
  localparam logic [STEP_W-1:0] STEP_RESET = 16'd655;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic CFG_TABLE_LENGTH = 1'b0;
  localparam logic CFG_HEIGHT_STEP  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NEG   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ABOVE = 2'd2;

  localparam logic [1:0] RES_ZERO = 2'd0;
  localparam logic [1:0] RES_PROD = 2'd1;
  localparam logic [1:0] RES_SUM  = 2'd2;

  localparam logic [1:0] MUL_DIFF = 2'd0;
  localparam logic [1:0] MUL_IDX  = 2'd1;
  localparam logic [1:0] MUL_LEN  = 2'd2;

  localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = 24'hFFFFFF;

  typedef struct packed {
    logic                accept;
    logic                rd_first;
    logic                advance;
    logic                mul_en;
    logic [1:0]          mul_sel;
    logic                den_load;
    logic                div_init;
    logic                div_step;
    logic                res_load;
    logic [1:0]          res_sel;
    logic [STATUS_W-1:0] res_status;
  } cmd_t;

  typedef struct packed {
    logic neg;
    logic zero;
    logic empty;
    logic hit;
    logic last;
    logic idx_zero;
  } stat_t;

endpackage

`default_nettype wire

### sv/rating_curve_height_lookup.sv
// Top level of the rating curve height lookup block: configuration registers,
// controller and datapath. Depends on rchl_pkg, rchl_ctrl and rchl_dpath.
//
// A request is taken when start is high and busy is low; each request gives
// exactly one result, shown for a single cycle with out_valid high, and the
// receiver cannot hold it off. The result of a table write appears in the
// next cycle. A query with a negative, zero or empty-table case is settled
// in the classify state. Otherwise the table is scanned one entry a cycle
// through the single read port of the rating memory; a query that stops at
// an entry after entry 0 has its height interpolated (two multiplies, a
// restoring divide and the final add), and a discharge above the table
// gives the height of its last entry.
// Configuration writes are always accepted and must only be made while busy
// is low and no result is outstanding.
`default_nettype none

module rating_curve_height_lookup #(
  parameter int TABLE_DEPTH = rchl_pkg::TABLE_DEPTH_DEF,
  parameter int REACH_COUNT = rchl_pkg::REACH_COUNT_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_op,
  input  wire logic [1:0]                    in_reach,
  input  wire logic [7:0]                    in_entry_index,
  input  wire logic [31:0]                   in_entry_discharge,
  input  wire logic signed [31:0]            in_query_discharge,
  output logic                               out_valid,
  output logic [rchl_pkg::HEIGHT_W-1:0]      out_height,
  output logic [rchl_pkg::STATUS_W-1:0]      out_status,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic                          cfg_index,
  input  wire logic [rchl_pkg::STEP_W-1:0]   cfg_data
);
  import rchl_pkg::*;

  logic [LEN_W-1:0]  table_length_r;
  logic [STEP_W-1:0] height_step_r;
  cmd_t              cmd;
  stat_t             stat;
  logic              start_ok;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_length_r <= LEN_RESET;
      height_step_r  <= STEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TABLE_LENGTH: table_length_r <= cfg_data[LEN_W-1:0];
        CFG_HEIGHT_STEP:  height_step_r  <= cfg_data;
        default:          table_length_r <= table_length_r;
      endcase
    end
  end

  assign start_ok = start;

  rchl_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_ok),
    .in_op (in_op),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  rchl_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .REACH_COUNT (REACH_COUNT)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_op              (in_op),
    .in_reach           (in_reach),
    .in_entry_index     (in_entry_index),
    .in_entry_discharge (in_entry_discharge),
    .in_query_discharge (in_query_discharge),
    .table_length       (table_length_r),
    .height_step        (height_step_r),
    .out_valid          (out_valid),
    .out_height         (out_height),
    .out_status         (out_status)
  );

endmodule

`default_nettype wire

### sv/rchl_ctrl.sv
// Controller state machine of the rating curve height lookup block.
// Sequences classification, table search, multiplies and division steps.
// Depends on rchl_pkg for the command and status structs.
`default_nettype none

module rchl_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic          in_op,
  input  wire rchl_pkg::stat_t stat,
  output rchl_pkg::cmd_t     cmd,
  output logic               busy
);
  import rchl_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_CLASSIFY = 3'd1;
  localparam logic [2:0] S_SEARCH   = 3'd2;
  localparam logic [2:0] S_MUL_H1   = 3'd3;
  localparam logic [2:0] S_DIVIDE   = 3'd4;
  localparam logic [2:0] S_FINISH   = 3'd5;
  localparam logic [2:0] S_ABOVE    = 3'd6;

  logic [2:0]           state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          if (in_op == OP_WRITE) begin
            // The table entry is written at the same edge; the result follows at once.
            cmd.res_load   = 1'b1;
            cmd.res_sel    = RES_ZERO;
            cmd.res_status = ST_OK;
          end else begin
            state_nxt = S_CLASSIFY;
          end
        end
      end
      S_CLASSIFY: begin
        priority if (stat.neg) begin
          cmd.res_load   = 1'b1;
          cmd.res_sel    = RES_ZERO;
          cmd.res_status = ST_NEG;
          state_nxt      = S_IDLE;
        end else if (stat.zero) begin
          cmd.res_load   = 1'b1;
          cmd.res_sel    = RES_ZERO;
          cmd.res_status = ST_OK;
          state_nxt      = S_IDLE;
        end else if (stat.empty) begin
          cmd.res_load   = 1'b1;
          cmd.res_sel    = RES_ZERO;
          cmd.res_status = ST_ABOVE;
          state_nxt      = S_IDLE;
        end else begin
          cmd.rd_first = 1'b1;
          state_nxt    = S_SEARCH;
        end
      end
      S_SEARCH: begin
        priority if (stat.hit) begin
          if (stat.idx_zero) begin
            cmd.res_load   = 1'b1;
            cmd.res_sel    = RES_ZERO;
            cmd.res_status = ST_OK;
            state_nxt      = S_IDLE;
          end else begin
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = MUL_DIFF;
            cmd.den_load = 1'b1;
            state_nxt    = S_MUL_H1;
          end
        end else if (stat.last) begin
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = MUL_LEN;
          state_nxt   = S_ABOVE;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      S_MUL_H1: begin
        // The divider takes the scaled difference while the multiplier moves on.
        cmd.div_init = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MUL_IDX;
        cnt_nxt      = '0;
        state_nxt    = S_DIVIDE;
      end
      S_DIVIDE: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(QUO_W - 1)) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd.res_load   = 1'b1;
        cmd.res_sel    = RES_SUM;
        cmd.res_status = ST_OK;
        state_nxt      = S_IDLE;
      end
      S_ABOVE: begin
        cmd.res_load   = 1'b1;
        cmd.res_sel    = RES_PROD;
        cmd.res_status = ST_ABOVE;
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### sv/rchl_dpath.sv
// Datapath of the rating curve height lookup block: rating table memory,
// search registers, shared multiplier, restoring divider and result registers.
// Depends on rchl_pkg; driven by rchl_ctrl through cmd_t.
`default_nettype none

module rchl_dpath #(
  parameter int TABLE_DEPTH = rchl_pkg::TABLE_DEPTH_DEF,
  parameter int REACH_COUNT = rchl_pkg::REACH_COUNT_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire rchl_pkg::cmd_t                cmd,
  output rchl_pkg::stat_t                    stat,
  input  wire logic                          in_op,
  input  wire logic [1:0]                    in_reach,
  input  wire logic [7:0]                    in_entry_index,
  input  wire logic [31:0]                   in_entry_discharge,
  input  wire logic signed [31:0]            in_query_discharge,
  input  wire logic [rchl_pkg::LEN_W-1:0]    table_length,
  input  wire logic [rchl_pkg::STEP_W-1:0]   height_step,
  output logic                               out_valid,
  output logic [rchl_pkg::HEIGHT_W-1:0]      out_height,
  output logic [rchl_pkg::STATUS_W-1:0]      out_status
);
  import rchl_pkg::*;

  localparam int MEM_DEPTH = REACH_COUNT * TABLE_DEPTH;
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam int IW        = $clog2(TABLE_DEPTH);
  localparam int CW        = (IW + 1 > LEN_W) ? IW + 1 : LEN_W;

  logic [DISCH_W-1:0] mem [MEM_DEPTH];

  logic [1:0]          reach_r;
  logic [DISCH_W-1:0]  q_r;
  logic [DISCH_W-1:0]  rdata_r;
  logic [DISCH_W-1:0]  prev_r;
  logic [IW-1:0]       cmp_idx_r;
  logic [PROD_W-1:0]   mul_r;
  logic [DISCH_W-1:0]  den_r;
  logic [DISCH_W-1:0]  rem_r;
  logic [QUO_W-1:0]    num_lo_r;
  logic [QUO_W-1:0]    quo_r;
  logic                out_valid_r;
  logic [HEIGHT_W-1:0] out_height_r;
  logic [STATUS_W-1:0] out_status_r;

  logic [CW-1:0]       tl_ext;
  logic [CW-1:0]       len;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic                rd_en;
  logic [IW-1:0]       rd_idx;
  logic [AW-1:0]       rd_addr;
  logic [DISCH_W-1:0]  mul_a;
  logic [PROD_W-1:0]   mul_p;
  logic [DISCH_W:0]    div_t;
  logic                div_ge;
  logic [PROD_W:0]     sum;
  logic [HEIGHT_W-1:0] res_height;

  // Table lengths above the depth act as the full depth.
  assign tl_ext = CW'(table_length);
  assign len    = (tl_ext > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : tl_ext;

  assign wr_en   = cmd.accept && (in_op == OP_WRITE) && (32'(in_reach) < REACH_COUNT)
                   && (32'(in_entry_index) < TABLE_DEPTH);
  assign wr_addr = AW'(32'(in_reach) * TABLE_DEPTH + 32'(in_entry_index));

  assign rd_en   = cmd.rd_first || cmd.advance;
  assign rd_idx  = cmd.rd_first ? '0 : IW'(cmp_idx_r + 1'b1);
  assign rd_addr = AW'(32'(reach_r) * TABLE_DEPTH + 32'(rd_idx));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_entry_discharge;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      reach_r <= in_reach;
      q_r     <= DISCH_W'(in_query_discharge);
    end
    if (cmd.rd_first) begin
      cmp_idx_r <= '0;
    end else if (cmd.advance) begin
      cmp_idx_r <= cmp_idx_r + 1'b1;
      prev_r    <= rdata_r;
    end
  end

  assign stat.neg      = q_r[DISCH_W-1];
  assign stat.zero     = (q_r == '0);
  assign stat.empty    = (32'(reach_r) >= REACH_COUNT) || (len == '0);
  assign stat.hit      = (rdata_r >= q_r);
  assign stat.last     = ((CW'(cmp_idx_r) + CW'(1)) == len);
  assign stat.idx_zero = (cmp_idx_r == '0);

  // One 32 x 16 multiplier serves the scaled difference and both base heights.
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_DIFF: mul_a = q_r - prev_r;
      MUL_IDX:  mul_a = DISCH_W'(cmp_idx_r - 1'b1);
      MUL_LEN:  mul_a = DISCH_W'(len - 1'b1);
      default:  mul_a = '0;
    endcase
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(height_step);

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      mul_r <= mul_p;
    end
    if (cmd.den_load) begin
      den_r <= rdata_r - prev_r;
    end
  end

  // Restoring division, one quotient bit a cycle. The quotient never exceeds
  // the height step, so the upper part of the dividend starts below the divisor.
  assign div_t  = {rem_r, num_lo_r[QUO_W-1]};
  assign div_ge = (div_t >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem_r    <= mul_r[PROD_W-1:QUO_W];
      num_lo_r <= mul_r[QUO_W-1:0];
      quo_r    <= '0;
    end else if (cmd.div_step) begin
      rem_r    <= div_ge ? DISCH_W'(div_t - {1'b0, den_r}) : DISCH_W'(div_t);
      num_lo_r <= {num_lo_r[QUO_W-2:0], 1'b0};
      quo_r    <= {quo_r[QUO_W-2:0], div_ge};
    end
  end

  assign sum = {1'b0, mul_r} + ((cmd.res_sel == RES_SUM) ? (PROD_W+1)'(quo_r) : '0);

  always_comb begin
    if (cmd.res_sel == RES_ZERO) begin
      res_height = '0;
    end else if (sum > (PROD_W+1)'(HEIGHT_MAX)) begin
      res_height = HEIGHT_MAX;
    end else begin
      res_height = sum[HEIGHT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_height_r <= res_height;
      out_status_r <= cmd.res_status;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_height = out_height_r;
  assign out_status = out_status_r;

endmodule

`default_nettype wire

### dv/rating_curve_height_lookup_test.sv
// Self-checking testbench for the rating curve height lookup block.
// Depends on rchl_pkg and the rating_curve_height_lookup top level; needs nothing else.
// A tracker class mirrors the rating tables and predicts the height and status of each request.
`timescale 1ns / 1ps

module rating_curve_height_lookup_test;
  import rchl_pkg::*;

  localparam int CYCLE_LIMIT  = 1_600_000;
  localparam int DRAIN_CYCLES = 300;
  localparam int FILL_NONE    = -2;
  localparam int FILL_SOME    = -1;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic [HEIGHT_W-1:0] height;
    logic [STATUS_W-1:0] status;
  } height_result_t;

  class height_tracker;
    logic [DISCH_W-1:0] rating [REACH_COUNT_DEF][TABLE_DEPTH_DEF];
    bit                 written [REACH_COUNT_DEF][TABLE_DEPTH_DEF];
    logic [LEN_W-1:0]   table_len;
    logic [STEP_W-1:0]  step;
    height_result_t     expected_q[$];
    int                 errors;

    function new();
      foreach (rating[r, i]) begin
        rating[r][i]  = '0;
        written[r][i] = 1'b0;
      end
      table_len = LEN_RESET;
      step      = STEP_RESET;
      errors    = 0;
    endfunction

    function int eff_len();
      return (int'(table_len) > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : int'(table_len);
    endfunction

    function void apply_config(logic idx, logic [STEP_W-1:0] data);
      if (idx == CFG_TABLE_LENGTH) table_len = data[LEN_W-1:0];
      else step = data;
    endfunction

    // True when a search for a positive discharge only touches entries already loaded.
    function bit scan_is_defined(int r, logic [DISCH_W-1:0] q);
      int len;
      len = eff_len();
      for (int i = 0; i < len; i++) begin
        if (!written[r][i]) return 1'b0;
        if (rating[r][i] >= q) return 1'b1;
      end
      return 1'b1;
    endfunction

    function logic [HEIGHT_W-1:0] clamp_height(u64_t h);
      return (h > u64_t'(HEIGHT_MAX)) ? HEIGHT_MAX : h[HEIGHT_W-1:0];
    endfunction

    function void note_request(logic op, logic [1:0] r, logic [7:0] idx,
                               logic [DISCH_W-1:0] wval, logic [DISCH_W-1:0] q);
      height_result_t res;
      int             len;
      int             i;
      u64_t           q1, q2, h1, frac;
      res.height = '0;
      res.status = ST_OK;
      if (op == OP_WRITE) begin
        rating[r][idx]  = wval;
        written[r][idx] = 1'b1;
      end else if (q[DISCH_W-1]) begin
        res.status = ST_NEG;
      end else if (q != '0) begin
        len = eff_len();
        if (len == 0) begin
          res.status = ST_ABOVE;
        end else begin
          i = 0;
          while (i < len && rating[r][i] < q) i++;
          if (i == len) begin
            res.height = clamp_height(u64_t'(len - 1) * u64_t'(step));
            res.status = ST_ABOVE;
          end else if (i != 0) begin
            // A hit at the first entry stays at height zero.
            q2   = u64_t'(rating[r][i]);
            q1   = u64_t'(rating[r][i-1]);
            h1   = u64_t'(i - 1) * u64_t'(step);
            frac = ((u64_t'(q) - q1) * u64_t'(step)) / (q2 - q1);
            res.height = clamp_height(h1 + frac);
          end
        end
      end
      expected_q = {expected_q, res};
    endfunction

    function void check_result(logic [HEIGHT_W-1:0] h, logic [STATUS_W-1:0] s);
      height_result_t res;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with no request outstanding: height %0d status %0d",
                 $time, h, s);
        return;
      end
      res = expected_q.pop_front();
      if (h !== res.height) begin
        errors++;
        $display("%0t: height mismatch: expected %0d actual %0d", $time, res.height, h);
      end
      if (s !== res.status) begin
        errors++;
        $display("%0t: status mismatch: expected %0d actual %0d", $time, res.status, s);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  in_op = OP_WRITE;
  logic [1:0]            in_reach = '0;
  logic [7:0]            in_entry_index = '0;
  logic [DISCH_W-1:0]    in_entry_discharge = '0;
  logic [DISCH_W-1:0]    in_query_discharge = '0;
  logic                  out_valid;
  logic [HEIGHT_W-1:0]   out_height;
  logic [STATUS_W-1:0]   out_status;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic                  cfg_index = CFG_TABLE_LENGTH;
  logic [STEP_W-1:0]     cfg_data = '0;

  height_tracker tracker = new();
  int            burst_left = 0;
  int            cycle_count = 0;

  rating_curve_height_lookup u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_op              (in_op),
    .in_reach           (in_reach),
    .in_entry_index     (in_entry_index),
    .in_entry_discharge (in_entry_discharge),
    .in_query_discharge (in_query_discharge),
    .out_valid          (out_valid),
    .out_height         (out_height),
    .out_status         (out_status),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid) tracker.check_result(out_height, out_status);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL rating_curve_height_lookup");
      $finish;
    end
  end

  // Presents one request, waits for it to be taken and then idles between bursts.
  task automatic send_request(input logic op, input logic [1:0] r, input logic [7:0] idx,
                              input logic [DISCH_W-1:0] wval, input logic [DISCH_W-1:0] q);
    int gap;
    in_op              <= op;
    in_reach           <= r;
    in_entry_index     <= idx;
    in_entry_discharge <= wval;
    in_query_discharge <= q;
    start              <= 1'b1;
    do @(posedge clk); while (busy);
    tracker.note_request(op, r, idx, wval, q);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap        = ($urandom_range(0, 4) == 0) ? 0 : int'($urandom_range(1, 12));
      burst_left = ($urandom_range(0, 9) == 0) ? int'($urandom_range(20, 80))
                                               : int'($urandom_range(1, 20));
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_until_drained();
    start <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0 || busy);
  endtask

  task automatic write_register(input logic idx, input logic [STEP_W-1:0] data);
    wait_until_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    tracker.apply_config(idx, data);
    cfg_valid <= 1'b0;
  endtask

  // One setting of the registers: optional monotonic table loads, then mixed traffic.
  task automatic run_phase(input logic [LEN_W-1:0] len9, input logic [STEP_W-1:0] step16,
                           input int n_mixed, input int fill_reach);
    int                 len, k, j, tries, roll, kind, r;
    u64_t               cur, t, d;
    logic [DISCH_W-1:0] v, q;
    bit                 ok;
    write_register(CFG_TABLE_LENGTH, {7'($urandom), len9});
    write_register(CFG_HEIGHT_STEP, step16);
    len = tracker.eff_len();
    if (fill_reach != FILL_NONE) begin
      for (r = 0; r < REACH_COUNT_DEF; r++) begin
        if ((fill_reach == FILL_SOME && $urandom_range(0, 3) != 0) || r == fill_reach) begin
          k   = int'($urandom_range(0, 24));
          cur = ($urandom_range(0, 3) == 0) ? 0 : u64_t'($urandom_range(0, 1 << k));
          for (j = 0; j < len; j++) begin
            v = (cur > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : cur[31:0];
            send_request(OP_WRITE, 2'(r), 8'(j), v, $urandom);
            if ($urandom_range(0, 9) != 0) cur += u64_t'($urandom_range(1, 1 << k));
          end
        end
      end
    end
    for (int n = 0; n < n_mixed; n++) begin
      roll = int'($urandom_range(0, 99));
      if (roll < 15) begin
        // Stray entry writes, which may break the ordering of a table.
        r = int'($urandom_range(0, 3));
        j = ($urandom_range(0, 1) == 0) ? int'($urandom_range(0, 255))
                                        : int'($urandom_range(0, (len < 255) ? len + 1 : 255));
        if (len > 0 && $urandom_range(0, 1) == 0)
          v = tracker.rating[r][$urandom_range(0, len - 1)];
        else
          v = $urandom;
        send_request(OP_WRITE, 2'(r), 8'(j), v, $urandom);
      end else if (roll < 22) begin
        send_request(OP_QUERY, 2'($urandom), 8'($urandom), $urandom, $urandom | 32'h8000_0000);
      end else if (roll < 26) begin
        send_request(OP_QUERY, 2'($urandom), 8'($urandom), $urandom, '0);
      end else begin
        ok    = 1'b0;
        tries = 0;
        r     = 0;
        q     = 32'd1;
        while (!ok && tries < 6) begin
          r    = int'($urandom_range(0, 3));
          kind = int'($urandom_range(0, 9));
          if (len == 0 || kind < 2) begin
            q = $urandom & 32'h7FFF_FFFF;
          end else begin
            t = u64_t'(tracker.rating[r][$urandom_range(0, len - 1)]);
            d = u64_t'($urandom_range(0, 1 << $urandom_range(0, 20)));
            if (kind < 5) t = (d >= t) ? 1 : t - d;
            else if (kind >= 7) t = t + d;
            q = (t > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : t[31:0];
          end
          if (q == '0) q = 32'd1;
          ok = tracker.scan_is_defined(r, q);
          tries++;
        end
        if (!ok) q = $urandom | 32'h8000_0000;
        send_request(OP_QUERY, 2'(r), 8'($urandom), $urandom, q);
      end
    end
  endtask

  initial begin
    int full_reach;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: empty table, negative and zero discharges.
    send_request(OP_QUERY, 2'd0, 8'd0, 32'h0, 32'h0000_0001);
    send_request(OP_QUERY, 2'd1, 8'hFF, 32'hFFFF_FFFF, 32'h8000_0000);
    send_request(OP_QUERY, 2'd2, 8'd0, 32'h0, 32'h0000_0000);
    send_request(OP_QUERY, 2'd3, 8'd0, 32'h0, 32'hFFFF_FFFF);
    send_request(OP_WRITE, 2'd0, 8'd0, 32'h0001_0000, 32'h0);
    send_request(OP_WRITE, 2'd0, 8'd1, 32'h0002_0000, 32'h0);
    send_request(OP_WRITE, 2'd0, 8'd2, 32'h0004_0000, 32'h0);
    send_request(OP_WRITE, 2'd2, 8'd0, 32'h0000_0000, 32'h0);
    send_request(OP_WRITE, 2'd2, 8'd1, 32'h0000_0000, 32'h0);
    send_request(OP_WRITE, 2'd2, 8'd2, 32'hFFFF_FFFF, 32'h0);
    send_request(OP_WRITE, 2'd3, 8'd255, 32'hA5A5_5A5A, 32'h0);
    // Height step is still at its reset value here.
    write_register(CFG_TABLE_LENGTH, 16'd3);
    send_request(OP_QUERY, 2'd0, 8'd0, 32'h0, 32'h0000_8000);
    send_request(OP_QUERY, 2'd0, 8'd0, 32'h0, 32'h0001_0000);
    send_request(OP_QUERY, 2'd0, 8'd0, 32'h0, 32'h0001_8000);
    send_request(OP_QUERY, 2'd0, 8'd0, 32'h0, 32'h0002_0000);
    send_request(OP_QUERY, 2'd0, 8'd0, 32'h0, 32'h0003_0000);
    send_request(OP_QUERY, 2'd0, 8'd0, 32'h0, 32'h7FFF_FFFF);
    send_request(OP_QUERY, 2'd2, 8'd0, 32'h0, 32'h7FFF_FFFF);
    send_request(OP_QUERY, 2'd2, 8'd0, 32'h0, 32'h0000_0001);
    write_register(CFG_HEIGHT_STEP, 16'hFFFF);
    send_request(OP_QUERY, 2'd0, 8'd0, 32'h0, 32'h7FFF_FFFF);
    send_request(OP_QUERY, 2'd2, 8'd0, 32'h0, 32'h7FFF_FFFF);
    write_register(CFG_HEIGHT_STEP, 16'd1);
    send_request(OP_QUERY, 2'd0, 8'd0, 32'h0, 32'h0001_8000);

    full_reach = int'($urandom_range(0, 3));
    run_phase(9'd2, 16'd1, 80, FILL_SOME);
    run_phase(9'd8, 16'hFFFF, 100, FILL_SOME);
    run_phase(9'($urandom_range(3, 16)), 16'($urandom), 100, FILL_SOME);
    run_phase(9'd6, 16'd0, 70, FILL_SOME);
    run_phase(9'd256, 16'hFFFF, 40, full_reach);
    // A length above the table depth behaves as the full depth.
    run_phase(9'd300, 16'd655, 40, FILL_NONE);
    run_phase(9'd0, 16'($urandom), 30, FILL_NONE);
    run_phase(9'($urandom_range(5, 12)), 16'hFFFF, 100, FILL_SOME);
    run_phase(9'($urandom_range(2, 16)), 16'($urandom_range(1, 65535)), 110, FILL_SOME);
    run_phase(9'd1, 16'($urandom), 50, FILL_SOME);

    wait_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("PASS rating_curve_height_lookup");
    end else begin
      $display("FAIL rating_curve_height_lookup");
    end
    $finish;
  end

endmodule

### rating_curve_height_lookup.f
sv/rchl_pkg.sv
sv/rchl_ctrl.sv
sv/rchl_dpath.sv
sv/rating_curve_height_lookup.sv
dv/rating_curve_height_lookup_test.sv
